// File: rtl/jbhc_pkg.sv
// Package for the JPEG baseline header checker: types, codes and helpers.
package jbhc_pkg;

   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned DIM_WIDTH   = 16;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned FRAME_POS_W = 3;

   localparam logic [DIM_WIDTH-1:0] MAX_DIM_RESET = 16'd2048;

   // marker bytes
   localparam logic [7:0] MK_PREFIX = 8'hff;
   localparam logic [7:0] MK_SOI    = 8'hd8;
   localparam logic [7:0] MK_SOS    = 8'hda;
   localparam logic [7:0] MK_EOI    = 8'hd9;
   localparam logic [7:0] MK_SOF0   = 8'hc0;
   localparam logic [7:0] MK_NULL   = 8'h00;
   localparam logic [7:0] MK_SOF1   = 8'hc1;
   localparam logic [7:0] MK_SOF3   = 8'hc3;
   localparam logic [7:0] MK_SOF5   = 8'hc5;
   localparam logic [7:0] MK_SOF15  = 8'hcf;
   localparam logic [7:0] MK_JPG    = 8'hc8;
   localparam logic [7:0] MK_DAC    = 8'hcc;

   localparam logic [7:0] BASE_PRECISION = 8'd8;

   // frame header byte positions after the length
   localparam logic [FRAME_POS_W-1:0] FP_PRECISION = 3'd0;
   localparam logic [FRAME_POS_W-1:0] FP_HEIGHT_HI = 3'd1;
   localparam logic [FRAME_POS_W-1:0] FP_HEIGHT_LO = 3'd2;
   localparam logic [FRAME_POS_W-1:0] FP_WIDTH_HI  = 3'd3;
   localparam logic [FRAME_POS_W-1:0] FP_WIDTH_LO  = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_WIDTH  = 1'b0,
      CSR_MAX_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_START0 = 3'd0,
      PH_START1 = 3'd1,
      PH_PREFIX = 3'd2,
      PH_MARKER = 3'd3,
      PH_LENHI  = 3'd4,
      PH_LENLO  = 3'd5,
      PH_SKIP   = 3'd6,
      PH_FRAME  = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      RSN_OK        = 3'd0,
      RSN_BAD_START = 3'd1,
      RSN_NO_FF     = 3'd2,
      RSN_FORBIDDEN = 3'd3,
      RSN_BAD_LEN   = 3'd4,
      RSN_BAD_SOF   = 3'd5,
      RSN_FRAME     = 3'd6,
      RSN_TRUNC     = 3'd7
   } reason_type;

   // SOF markers other than baseline that this checker refuses
   function automatic logic unsupported_sof(input logic [7:0] m);
      logic r;
      r = ((m >= MK_SOF1) && (m <= MK_SOF3)) ||
          ((m >= MK_SOF5) && (m <= MK_SOF15) && (m != MK_JPG) && (m != MK_DAC));
      return r;
   endfunction

endpackage

// File: rtl/jpeg_baseline_header_check.sv
// JPEG baseline header checker: byte-wise marker walk and SOF0 frame check.
//
// Takes a JPEG file one byte per word on the req_ channel (req_last_byte marks
// the final byte) and gives one verdict word per file on the rsp_ channel:
// accepted, a reason code and, for ok and frame-check verdicts, the SOF0 width,
// height and component count (zero otherwise). The file must open with FF D8;
// marker segments are then walked, FF fill bytes skipped, ordinary segments
// skipped by length, and the first SOF0 header is checked against max_width
// and max_height (csr_ index 0 and 1, both 2048 after reset). The verdict
// comes at the deciding byte, or at the last byte (reason truncated) if none
// was reached; bytes after a verdict give nothing until the last byte, which
// rearms the checker for the next file. Rate: one byte per cycle while no
// byte waits on the result register; each byte is decided by single-pass
// logic between the input register and the result register, so rsp_valid
// is registered and rises once the deciding byte is processed.
// While a verdict word waits on rsp_ready, bytes that give no word keep
// flowing; only a byte that would give another verdict word waits in the
// input register, and req_ready drops with it. CSR writes are always taken
// and must be issued while idle.
module jpeg_baseline_header_check (
   input  logic                           clock,
   input  logic                           reset,
   // byte input
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [jbhc_pkg::BYTE_WIDTH-1:0] req_data_byte,
   input  logic                           req_last_byte,
   // verdict output
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic [2:0]                     rsp_reason,
   output logic [jbhc_pkg::DIM_WIDTH-1:0] rsp_image_width,
   output logic [jbhc_pkg::DIM_WIDTH-1:0] rsp_image_height,
   output logic [jbhc_pkg::BYTE_WIDTH-1:0] rsp_component_count,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [jbhc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [jbhc_pkg::DIM_WIDTH-1:0] csr_data
);
   import jbhc_pkg::*;

   // limit registers
   logic [DIM_WIDTH-1:0] max_width_ff, max_height_ff;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_WIDTH-1:0] byte_ff;
   logic                  last_ff;

   // parser state
   phase_type              phase_ff, phase_in;
   logic [7:0]             marker_ff, marker_in;
   logic [DIM_WIDTH-1:0]   seg_len_ff, seg_len_in;
   logic [DIM_WIDTH-1:0]   skip_ff, skip_in;
   logic [FRAME_POS_W-1:0] frame_pos_ff, frame_pos_in;
   logic [7:0]             precision_ff, precision_in;
   logic [DIM_WIDTH-1:0]   height_ff, height_in;
   logic [DIM_WIDTH-1:0]   width_ff, width_in;
   logic                   verdict_ff, verdict_in;

   // result register
   logic                   rsp_valid_ff;
   logic                   rsp_accepted_ff;
   reason_type             rsp_reason_ff;
   logic [DIM_WIDTH-1:0]   rsp_width_ff, rsp_height_ff;
   logic [BYTE_WIDTH-1:0]  rsp_count_ff;

   logic advance;    // result register can take a word
   logic res_cand;   // byte in the input register would give a verdict word
   logic proc;       // byte in the input register is processed this cycle
   logic decided;    // this byte settles the verdict
   reason_type why;
   logic result_out; // a verdict word is produced
   reason_type out_reason;
   logic echo;       // verdict carries frame fields

   logic [DIM_WIDTH-1:0] len_full;
   logic [9:0]           len_need;
   logic                 frame_ok;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign res_cand  = !verdict_ff && (decided || last_ff);
   // a byte that gives no word never waits on the result register
   assign proc      = in_valid_ff && (advance || !res_cand);
   assign req_ready = !in_valid_ff || proc;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         max_width_ff  <= MAX_DIM_RESET;
         max_height_ff <= MAX_DIM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_WIDTH:  max_width_ff  <= csr_data;
            CSR_MAX_HEIGHT: max_height_ff <= csr_data;
         endcase
      end
   end

   // ---------------------------------------------------------------- input register
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

   // ---------------------------------------------------------------- decode helpers
   assign len_full = {seg_len_ff[15:8], byte_ff};
   // 8 + 3 * component count
   assign len_need = 10'd8 + {2'b00, byte_ff} + {1'b0, byte_ff, 1'b0};
   assign frame_ok = (precision_ff == BASE_PRECISION) &&
                     (width_ff != '0) && (width_ff <= max_width_ff) &&
                     (height_ff != '0) && (height_ff <= max_height_ff) &&
                     ((byte_ff == 8'd1) || (byte_ff == 8'd3)) &&
                     (seg_len_ff == {6'd0, len_need});

   // ---------------------------------------------------------------- next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_START0: phase_in = PH_START1;
         PH_START1: phase_in = PH_PREFIX;
         PH_PREFIX: phase_in = PH_MARKER;
         PH_MARKER: if (byte_ff != MK_PREFIX) begin
            phase_in = PH_LENHI;
         end
         PH_LENHI:  phase_in = PH_LENLO;
         PH_LENLO: begin
            if (marker_ff == MK_SOF0) begin
               phase_in = PH_FRAME;
            end else if (len_full == 16'd2) begin
               phase_in = PH_PREFIX;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: if (skip_ff == 16'd1) begin
            phase_in = PH_PREFIX;
         end
         PH_FRAME:  phase_in = PH_FRAME;
      endcase
      // a deciding byte leaves phase unused until the file ends
      if (!proc || verdict_ff) begin
         phase_in = phase_ff;
      end
      if (proc && last_ff) begin
         phase_in = PH_START0;
      end
   end

   // ---------------------------------------------------------------- datapath / verdict
   always_comb begin
      marker_in    = marker_ff;
      seg_len_in   = seg_len_ff;
      skip_in      = skip_ff;
      frame_pos_in = frame_pos_ff;
      precision_in = precision_ff;
      height_in    = height_ff;
      width_in     = width_ff;
      decided      = 1'b0;
      why          = RSN_OK;

      unique case (phase_ff)
         PH_START0: if (byte_ff != MK_PREFIX) begin
            decided = 1'b1;
            why     = RSN_BAD_START;
         end
         PH_START1: if (byte_ff != MK_SOI) begin
            decided = 1'b1;
            why     = RSN_BAD_START;
         end
         PH_PREFIX: if (byte_ff != MK_PREFIX) begin
            decided = 1'b1;
            why     = RSN_NO_FF;
         end
         PH_MARKER: begin
            if ((byte_ff == MK_NULL) || (byte_ff == MK_SOS) || (byte_ff == MK_EOI)) begin
               decided = 1'b1;
               why     = RSN_FORBIDDEN;
            end
            marker_in = byte_ff;
         end
         PH_LENHI:  seg_len_in = {byte_ff, 8'h00};
         PH_LENLO: begin
            seg_len_in   = len_full;
            skip_in      = len_full - 16'd2;
            frame_pos_in = FP_PRECISION;
            priority if (len_full < 16'd2) begin
               decided = 1'b1;
               why     = RSN_BAD_LEN;
            end else if (marker_ff == MK_SOF0 && len_full < 16'd8) begin
               decided = 1'b1;
               why     = RSN_BAD_LEN;
            end else if (marker_ff != MK_SOF0 && unsupported_sof(marker_ff)) begin
               decided = 1'b1;
               why     = RSN_BAD_SOF;
            end
         end
         PH_SKIP:   skip_in = skip_ff - 16'd1;
         PH_FRAME: begin
            frame_pos_in = frame_pos_ff + 3'd1;
            unique case (frame_pos_ff)
               FP_PRECISION: precision_in = byte_ff;
               FP_HEIGHT_HI: height_in    = {byte_ff, 8'h00};
               FP_HEIGHT_LO: height_in    = {height_ff[15:8], byte_ff};
               FP_WIDTH_HI:  width_in     = {byte_ff, 8'h00};
               FP_WIDTH_LO:  width_in     = {width_ff[15:8], byte_ff};
               default: begin
                  decided = 1'b1;
                  why     = frame_ok ? RSN_OK : RSN_FRAME;
               end
            endcase
         end
      endcase
   end

   // verdict word: deciding byte first, else truncation at the last byte
   assign result_out = proc && res_cand;
   assign out_reason = decided ? why : RSN_TRUNC;
   assign echo       = decided && ((why == RSN_OK) || (why == RSN_FRAME));
   assign verdict_in = (proc && last_ff) ? 1'b0 : (verdict_ff || result_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START0;
         verdict_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         verdict_ff <= verdict_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && !verdict_ff) begin
         marker_ff    <= marker_in;
         seg_len_ff   <= seg_len_in;
         skip_ff      <= skip_in;
         frame_pos_ff <= frame_pos_in;
         precision_ff <= precision_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
      end
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= result_out;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_out) begin
         rsp_accepted_ff <= decided && (why == RSN_OK);
         rsp_reason_ff   <= out_reason;
         rsp_width_ff    <= echo ? width_ff  : '0;
         rsp_height_ff   <= echo ? height_ff : '0;
         rsp_count_ff    <= echo ? byte_ff   : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_accepted_ff;
   assign rsp_reason          = rsp_reason_ff;
   assign rsp_image_width     = rsp_width_ff;
   assign rsp_image_height    = rsp_height_ff;
   assign rsp_component_count = rsp_count_ff;

   // ---------------------------------------------------------------- assertions
   // no second verdict for a file
   a_one_verdict: assert property (@(posedge clock) disable iff (reset)
      (proc && verdict_ff) |-> !result_out)
      else $error("verdict produced twice for one file");

   // a stalled input byte is neither dropped nor altered
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !proc) |=> (in_valid_ff && $stable(byte_ff) && $stable(last_ff)))
      else $error("input byte lost while stalled");

   // last byte rearms the checker
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (proc && last_ff) |=> (phase_ff == PH_START0 && !verdict_ff))
      else $error("checker not rearmed after last byte");

   // only ok and frame verdicts echo frame fields; accepted only for ok
   a_echo: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reason != RSN_OK && rsp_reason != RSN_FRAME) |->
      (!rsp_accepted && rsp_image_width == '0 && rsp_image_height == '0 &&
       rsp_component_count == '0))
      else $error("frame fields echoed on a marker-level verdict");

endmodule
